### hw/rtl/oss_pkg.sv
`default_nettype none

package oss_pkg;

    localparam int MAX_SIZE_BYTES = 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    localparam int HDR_EXT_BIT = 2;
    localparam int HDR_SIZE_BIT = 1;
    localparam int HDR_TYPE_LSB = 3;
    localparam int HDR_TYPE_MSB = 6;
    localparam int LEB_MORE_BIT = 7;

    typedef enum logic [2:0] {
        ROLE_HEADER  = 3'd0,
        ROLE_EXT     = 3'd1,
        ROLE_SIZE    = 3'd2,
        ROLE_PAYLOAD = 3'd3,
        ROLE_DISCARD = 3'd4
    } role_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_MISS_EXT  = 2'd1,
        ERR_BAD_SIZE  = 2'd2,
        ERR_TRUNCATED = 2'd3
    } err_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [2:0]  byte_role;
        logic [3:0]  unit_type;
        logic        has_ext;
        logic        unit_end;
        logic [56:0] unit_size;
        logic [1:0]  error_code;
        logic        packet_end;
    } result_t;

    // classified byte as it travels from parser to output stage
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        role_t       role;
        logic [3:0]  unit_type;
        logic        has_ext;
        logic        unit_end;
        logic [56:0] unit_count;
        err_t        err;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t entry;
    } push_t;

endpackage

`default_nettype wire

### hw/rtl/obu_stream_splitter.sv
// a byte's result becomes valid once it has passed through the queue and then the output register
// throughput: one byte per cycle while the queue is not full, one result per byte
// the parser state is updated in the cycle of the transfer; a four-entry queue and an
// output register follow it, so input stalls only when the queue is full
// reset clears parser state, queue pointers and output valid; no clearing pass
`default_nettype none

module obu_stream_splitter (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire oss_pkg::item_t    item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output oss_pkg::result_t       result
);

    oss_pkg::push_t  push;
    oss_pkg::entry_t head;
    logic            queue_full;
    logic            not_empty;
    logic            pop;

    oss_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .queue_full (queue_full),
        .item_stall (item_stall),
        .push       (push)
    );

    oss_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (not_empty),
        .head      (head)
    );

    oss_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .not_empty    (not_empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

### hw/rtl/oss_front.sv
`default_nettype none

module oss_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    input  wire oss_pkg::item_t item,
    input  wire logic          queue_full,
    output logic               item_stall,
    output oss_pkg::push_t     push
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_EXT,
        PH_SIZE,
        PH_PAYLOAD,
        PH_DISCARD
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic [3:0]   cur_type_reg, cur_type_next;
    logic         cur_ext_reg, cur_ext_next;
    logic         cur_sized_reg, cur_sized_next;
    logic [55:0]  size_accum_reg, size_accum_next;
    logic [3:0]   size_idx_reg, size_idx_next;
    logic [55:0]  payload_left_reg, payload_left_next;
    logic [56:0]  unit_count_reg, unit_count_next;

    logic          accept;
    logic [7:0]    b;
    logic          last;
    logic [6:0]    part;
    logic [5:0]    sh;
    logic [55:0]   shifted;
    logic [55:0]   accum_new;
    logic [55:0]   left_dec;
    logic [56:0]   cnt_inc;
    logic [56:0]   count_rep;
    logic          do_prefix;
    logic          prefix_sized;
    logic          unit_end;
    oss_pkg::role_t role;
    oss_pkg::err_t  err;

    assign accept = item_valid && !queue_full;
    assign item_stall = queue_full;
    assign b = item.data_byte;
    assign last = item.last_byte;
    assign part = b[6:0];
    assign sh = {size_idx_reg[2:0], 3'b000} - {3'b000, size_idx_reg[2:0]};
    assign shifted = {49'd0, part} << sh;
    assign left_dec = payload_left_reg - 56'd1;
    assign cnt_inc = (unit_count_reg == '1) ? unit_count_reg : unit_count_reg + 57'd1;

    always_comb
    begin
        phase_next = phase_reg;
        cur_type_next = cur_type_reg;
        cur_ext_next = cur_ext_reg;
        cur_sized_next = cur_sized_reg;
        size_accum_next = size_accum_reg;
        size_idx_next = size_idx_reg;
        payload_left_next = payload_left_reg;
        unit_count_next = unit_count_reg;
        count_rep = unit_count_reg;
        role = oss_pkg::ROLE_DISCARD;
        err = oss_pkg::ERR_NONE;
        unit_end = 1'b0;
        do_prefix = 1'b0;
        prefix_sized = cur_sized_reg;
        accum_new = size_accum_reg;

        case (phase_reg)
            PH_HEADER:
            begin
                role = oss_pkg::ROLE_HEADER;
                cur_type_next = b[oss_pkg::HDR_TYPE_MSB:oss_pkg::HDR_TYPE_LSB];
                cur_ext_next = b[oss_pkg::HDR_EXT_BIT];
                cur_sized_next = b[oss_pkg::HDR_SIZE_BIT];
                unit_count_next = 57'd1;
                count_rep = 57'd1;
                if (b[oss_pkg::HDR_EXT_BIT])
                begin
                    if (last)
                        err = oss_pkg::ERR_MISS_EXT;
                    else
                        phase_next = PH_EXT;
                end
                else
                begin
                    do_prefix = 1'b1;
                    prefix_sized = b[oss_pkg::HDR_SIZE_BIT];
                end
            end
            PH_EXT:
            begin
                role = oss_pkg::ROLE_EXT;
                unit_count_next = cnt_inc;
                count_rep = cnt_inc;
                do_prefix = 1'b1;
            end
            PH_SIZE:
            begin
                role = oss_pkg::ROLE_SIZE;
                // past the eighth group any set bit overflows 56 bits
                if (part != 7'd0)
                    accum_new = size_idx_reg[3] ? '1 : (size_accum_reg | shifted);
                size_accum_next = accum_new;
                size_idx_next = size_idx_reg + 4'd1;
                if (b[oss_pkg::LEB_MORE_BIT])
                begin
                    if ((size_idx_next >= 4'(oss_pkg::MAX_SIZE_BYTES)) || last)
                        err = oss_pkg::ERR_BAD_SIZE;
                end
                else if (accum_new == 56'd0)
                begin
                    unit_end = 1'b1;
                    phase_next = PH_HEADER;
                end
                else if (last)
                    err = oss_pkg::ERR_TRUNCATED;
                else
                begin
                    payload_left_next = accum_new;
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                role = oss_pkg::ROLE_PAYLOAD;
                unit_count_next = cnt_inc;
                count_rep = cnt_inc;
                if (cur_sized_reg)
                begin
                    payload_left_next = left_dec;
                    if (left_dec == 56'd0)
                    begin
                        unit_end = 1'b1;
                        phase_next = PH_HEADER;
                    end
                    else if (last)
                        err = oss_pkg::ERR_TRUNCATED;
                end
                else if (last)
                    unit_end = 1'b1;
            end
            default:
            begin
                role = oss_pkg::ROLE_DISCARD;
            end
        endcase

        if (do_prefix)
        begin
            if (prefix_sized)
            begin
                if (last)
                    err = oss_pkg::ERR_BAD_SIZE;
                else
                begin
                    size_accum_next = 56'd0;
                    size_idx_next = 4'd0;
                    phase_next = PH_SIZE;
                end
            end
            else if (last)
                unit_end = 1'b1;
            else
                phase_next = PH_PAYLOAD;
        end

        if (err != oss_pkg::ERR_NONE)
            phase_next = PH_DISCARD;
        if (last)
            phase_next = PH_HEADER;
    end

    always_comb
    begin
        push.push = accept;
        push.entry.data_byte = b;
        push.entry.last_byte = last;
        push.entry.role = role;
        push.entry.unit_type = cur_type_next;
        push.entry.has_ext = cur_ext_next;
        push.entry.unit_end = unit_end;
        push.entry.unit_count = count_rep;
        push.entry.err = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            cur_type_reg <= 4'd0;
            cur_ext_reg <= 1'b0;
            cur_sized_reg <= 1'b0;
            size_accum_reg <= 56'd0;
            size_idx_reg <= 4'd0;
            payload_left_reg <= 56'd0;
            unit_count_reg <= 57'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cur_type_reg <= cur_type_next;
            cur_ext_reg <= cur_ext_next;
            cur_sized_reg <= cur_sized_next;
            size_accum_reg <= size_accum_next;
            size_idx_reg <= size_idx_next;
            payload_left_reg <= payload_left_next;
            unit_count_reg <= unit_count_next;
        end
    end

    a_last_resyncs: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> phase_reg == PH_HEADER)
        else $error("packet end did not return parser to header");

    a_end_err_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !(unit_end && err != oss_pkg::ERR_NONE))
        else $error("unit end flagged together with an error");

    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_EXT || phase_reg == PH_SIZE || phase_reg == PH_PAYLOAD)
        |-> unit_count_reg != 57'd0)
        else $error("unit byte count lost inside a unit");

    a_discard_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_DISCARD
        |-> !unit_end && err == oss_pkg::ERR_NONE && role == oss_pkg::ROLE_DISCARD)
        else $error("discarded byte carries tags");

endmodule

`default_nettype wire

### hw/rtl/oss_queue.sv
`default_nettype none

module oss_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire oss_pkg::push_t  push,
    input  wire logic            pop,
    output logic                 full,
    output logic                 not_empty,
    output oss_pkg::entry_t      head
);

    oss_pkg::entry_t mem_reg [oss_pkg::QUEUE_DEPTH];

    logic [oss_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [oss_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [oss_pkg::QUEUE_AW:0]   count_reg, count_next;
    logic                         do_pop;

    assign full = count_reg == (oss_pkg::QUEUE_AW + 1)'(oss_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head = mem_reg[rd_ptr_reg];
    assign do_pop = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push.push)
            wr_ptr_next = (wr_ptr_reg == (oss_pkg::QUEUE_AW)'(oss_pkg::QUEUE_DEPTH - 1))
                ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == (oss_pkg::QUEUE_AW)'(oss_pkg::QUEUE_DEPTH - 1))
                ? '0 : rd_ptr_reg + 1'b1;
        case ({push.push, do_pop})
            2'b10: count_next = count_reg + 1'b1;
            2'b01: count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
            mem_reg[wr_ptr_reg] <= push.entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/oss_back.sv
`default_nettype none

module oss_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             not_empty,
    input  wire oss_pkg::entry_t  head,
    output logic                  pop,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output oss_pkg::result_t      result
);

    logic             valid_reg;
    oss_pkg::result_t result_reg, result_next;
    logic             discard;

    assign pop = not_empty && (!valid_reg || !result_stall);
    assign discard = head.role == oss_pkg::ROLE_DISCARD;
    assign result_valid = valid_reg;
    assign result = result_reg;

    always_comb
    begin
        result_next.byte_out = head.data_byte;
        result_next.byte_role = head.role;
        result_next.unit_type = discard ? 4'd0 : head.unit_type;
        result_next.has_ext = discard ? 1'b0 : head.has_ext;
        result_next.unit_end = head.unit_end;
        result_next.unit_size = head.unit_end ? head.unit_count : 57'd0;
        result_next.error_code = head.err;
        result_next.packet_end = head.last_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (!result_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            result_reg <= result_next;
    end

endmodule

`default_nettype wire
